// ===== hw/rtl/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssc_pkg: state-space controller shared definitions
// Number formats, coefficient ROM, controller/datapath interface types and
// the saturation helper.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int unsigned NUM_STATES  = 5;
  localparam int unsigned NUM_INPUTS  = 3;
  localparam int unsigned NUM_OUTPUTS = 1;

  localparam int unsigned NUM_TERMS = NUM_STATES + NUM_INPUTS;
  localparam int unsigned NUM_ROWS  = NUM_OUTPUTS + NUM_STATES;

  localparam int unsigned ROW_W = $clog2(NUM_ROWS);
  localparam int unsigned COL_W = $clog2(NUM_TERMS);
  localparam int unsigned ST_W  = $clog2(NUM_STATES);
  localparam int unsigned IN_W  = $clog2(NUM_INPUTS);

  localparam int unsigned Q_W    = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned PROD_W = 2 * Q_W;
  localparam int unsigned TERM_W = PROD_W - FRAC_W;
  localparam int unsigned ACC_W  = TERM_W + COL_W + 1;

  typedef logic signed [Q_W-1:0]    q16_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  localparam prod_t ROUND_HALF = prod_t'(1) <<< (FRAC_W - 1);

  localparam q16_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam q16_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  // Row 0: C | D, rows 1..NUM_STATES: A | B
  localparam q16_t COEF [NUM_ROWS][NUM_TERMS] = '{
    '{  32'sd2291329,  32'sd1156461,  32'sd0,       32'sd5374679,  -32'sd3002,
       -32'sd1144422,  32'sd0,        32'sd0 },
    '{  32'sd147664,   32'sd83011,    32'sd1287,    32'sd384295,    32'sd1800,
       -32'sd82129,   -32'sd51,      -32'sd12 },
    '{ -32'sd164007,  -32'sd100433,  -32'sd55710,  -32'sd903250,   -32'sd3584,
        32'sd164009,   32'sd2228,     32'sd148697 },
    '{  32'sd1018,     32'sd366,      32'sd65190,   32'sd1584,      32'sd24,
       -32'sd362,      32'sd14,       32'sd108 },
    '{ -32'sd724,     -32'sd78,      -32'sd2449,    32'sd47591,    -32'sd49,
        32'sd724,      32'sd98,       32'sd14630 },
    '{  32'sd373219,   32'sd376721,  -32'sd16749,   32'sd1772290,  -32'sd31788,
       -32'sd373163,   32'sd670,      32'sd3296 }
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } ssc_state_e;

  typedef struct packed {
    logic             accept;
    logic             load;
    logic             issue;
    logic             first;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             commit;
  } ssc_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } ssc_stat_t;

  function automatic q16_t sat_q16(acc_t v);
    logic [ACC_W-Q_W:0] upper;
    upper = v[ACC_W-1:Q_W-1];
    if ((&upper) || !(|upper)) begin
      sat_q16 = v[Q_W-1:0];
    end else if (v[ACC_W-1]) begin
      sat_q16 = Q_MIN;
    end else begin
      sat_q16 = Q_MAX;
    end
  endfunction

endpackage

// ===== hw/rtl/ssc_datapath.sv =====
// ----------------------------------------------------------------------------
// ssc_datapath: state-space controller datapath
// State and input registers, one shared multiply-accumulate pipeline
// (operand select, product, round and accumulate) and the result register.
// ----------------------------------------------------------------------------
module ssc_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ssc_pkg::ssc_cmd_t  cmd_i,
  output ssc_pkg::ssc_stat_t stat_o,
  input  logic signed [31:0] input_0_i,
  input  logic signed [31:0] input_1_i,
  input  logic signed [31:0] input_2_i,
  input  logic signed [31:0] load_state_0_i,
  input  logic signed [31:0] load_state_1_i,
  input  logic signed [31:0] load_state_2_i,
  input  logic signed [31:0] load_state_3_i,
  input  logic signed [31:0] load_state_4_i,
  output logic signed [31:0] drive_o,
  output logic signed [31:0] state_0_o,
  output logic signed [31:0] state_1_o,
  output logic signed [31:0] state_2_o,
  output logic signed [31:0] state_3_o,
  output logic signed [31:0] state_4_o
);
  import ssc_pkg::*;

  q16_t x_q     [NUM_STATES];
  q16_t nxt_q   [NUM_STATES];
  q16_t u_q     [NUM_INPUTS];
  q16_t drive_q;
  q16_t out_drive_q;
  q16_t out_state_q [NUM_STATES];

  q16_t             sel_sig;
  logic [COL_W-1:0] uidx;

  q16_t             coef_q;
  q16_t             sig_q;
  logic             v1_q;
  logic             first1_q;
  logic             last1_q;
  logic [ROW_W-1:0] row1_q;

  prod_t            prod_q;
  logic             v2_q;
  logic             first2_q;
  logic             last2_q;
  logic [ROW_W-1:0] row2_q;

  acc_t             acc_q;
  acc_t             acc_base;
  acc_t             acc_sum;
  prod_t            rnd;
  term_t            term;
  q16_t             sat_val;
  logic [ROW_W-1:0] dst;

  always_comb begin
    uidx = COL_W'(cmd_i.col - COL_W'(NUM_STATES));
    if (cmd_i.col < COL_W'(NUM_STATES)) begin
      sel_sig = x_q[cmd_i.col[ST_W-1:0]];
    end else begin
      sel_sig = u_q[uidx[IN_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    coef_q   <= COEF[cmd_i.row][cmd_i.col];
    sig_q    <= sel_sig;
    first1_q <= cmd_i.first;
    last1_q  <= cmd_i.last;
    row1_q   <= cmd_i.row;
    prod_q   <= prod_t'(coef_q) * prod_t'(sig_q);
    first2_q <= first1_q;
    last2_q  <= last1_q;
    row2_q   <= row1_q;
  end

  always_comb begin
    rnd = prod_q + ROUND_HALF;
    term = rnd[PROD_W-1:FRAC_W];
    if (first2_q) begin
      acc_base = '0;
    end else begin
      acc_base = acc_q;
    end
    acc_sum = acc_base + acc_t'(term);
    sat_val = sat_q16(acc_sum);
    dst     = ROW_W'(row2_q - ROW_W'(NUM_OUTPUTS));
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      acc_q <= acc_sum;
      if (last2_q) begin
        if (row2_q < ROW_W'(NUM_OUTPUTS)) begin
          drive_q <= sat_val;
        end else begin
          nxt_q[dst[ST_W-1:0]] <= sat_val;
        end
      end
    end
    if (cmd_i.accept) begin
      if (cmd_i.load) begin
        nxt_q[0] <= load_state_0_i;
        nxt_q[1] <= load_state_1_i;
        nxt_q[2] <= load_state_2_i;
        nxt_q[3] <= load_state_3_i;
        nxt_q[4] <= load_state_4_i;
        drive_q  <= '0;
      end else begin
        u_q[0] <= input_0_i;
        u_q[1] <= input_1_i;
        u_q[2] <= input_2_i;
      end
    end
    if (cmd_i.commit) begin
      out_drive_q <= drive_q;
      out_state_q <= nxt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STATES; i++) begin
        x_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      x_q <= nxt_q;
    end
  end

  assign stat_o.pipe_busy = v1_q | v2_q;

  assign drive_o   = out_drive_q;
  assign state_0_o = out_state_q[0];
  assign state_1_o = out_state_q[1];
  assign state_2_o = out_state_q[2];
  assign state_3_o = out_state_q[3];
  assign state_4_o = out_state_q[4];

endmodule

// ===== hw/rtl/ssc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssc_ctrl: state-space controller sequencer
// Accepts items, steps the multiply-accumulate schedule row by row, drains
// the pipeline and hands the result to the output register.
// ----------------------------------------------------------------------------
module ssc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ssc_pkg::ssc_cmd_t  cmd_o,
  input  ssc_pkg::ssc_stat_t stat_i
);
  import ssc_pkg::*;

  ssc_state_e       state_q, state_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    col_d        = col_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.row    = row_q;
    cmd_o.col    = col_q;
    cmd_o.first  = (col_q == '0);
    cmd_o.last   = (col_q == COL_W'(NUM_TERMS - 1));
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          cmd_o.load   = operation_i;
          row_d        = '0;
          col_d        = '0;
          state_d      = operation_i ? ST_DONE : ST_MAC;
        end
      end
      ST_MAC: begin
        cmd_o.issue = 1'b1;
        if (col_q == COL_W'(NUM_TERMS - 1)) begin
          col_d = '0;
          if (row_q == ROW_W'(NUM_ROWS - 1)) begin
            state_d = ST_DRAIN;
          end else begin
            row_d = ROW_W'(row_q + 1'b1);
          end
        end else begin
          col_d = COL_W'(col_q + 1'b1);
        end
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_idle_pipe_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !stat_i.pipe_busy)
    else $error("pipeline busy while idle");

  a_commit_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("result not presented after commit");

  a_done_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !out_ready_i) |=> (state_q == ST_DONE))
    else $error("result overwritten while output stalled");

  a_mac_to_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC && row_q == ROW_W'(NUM_ROWS - 1) &&
     col_q == COL_W'(NUM_TERMS - 1)) |=> (state_q == ST_DRAIN))
    else $error("schedule did not end after last term");

  a_no_issue_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |-> !stat_i.pipe_busy && !cmd_o.issue)
    else $error("item accepted while datapath busy");

endmodule

// ===== hw/rtl/state_space_controller.sv =====
// ----------------------------------------------------------------------------
// state_space_controller: discrete state-space controller
// Run items return y = C*x + D*u and advance x = A*x + B*u; load items set
// the state. Signed Q16.16 throughout, saturating sums.
// ----------------------------------------------------------------------------
// A run item (operation 0) goes from acceptance through the multiply-
// accumulates on the single shared 32x32 multiplier (one row of 8 terms for
// the drive and one per state element), a drain of the multiply pipeline and
// a move of the result into the output register, before the next acceptance.
// A load item (operation 1) goes straight from acceptance to that move.
// The output register lets the block take the next item while a result still
// waits; a finished item waits for that register to free up. Every result
// carries the state vector after the item; the drive is zero for a load.
module state_space_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic signed [31:0] input_0_i,
  input  logic signed [31:0] input_1_i,
  input  logic signed [31:0] input_2_i,
  input  logic signed [31:0] load_state_0_i,
  input  logic signed [31:0] load_state_1_i,
  input  logic signed [31:0] load_state_2_i,
  input  logic signed [31:0] load_state_3_i,
  input  logic signed [31:0] load_state_4_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] drive_o,
  output logic signed [31:0] state_0_o,
  output logic signed [31:0] state_1_o,
  output logic signed [31:0] state_2_o,
  output logic signed [31:0] state_3_o,
  output logic signed [31:0] state_4_o
);
  import ssc_pkg::*;

  ssc_cmd_t  cmd;
  ssc_stat_t stat;

  ssc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  ssc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .input_0_i      (input_0_i),
    .input_1_i      (input_1_i),
    .input_2_i      (input_2_i),
    .load_state_0_i (load_state_0_i),
    .load_state_1_i (load_state_1_i),
    .load_state_2_i (load_state_2_i),
    .load_state_3_i (load_state_3_i),
    .load_state_4_i (load_state_4_i),
    .drive_o        (drive_o),
    .state_0_o      (state_0_o),
    .state_1_o      (state_1_o),
    .state_2_o      (state_2_o),
    .state_3_o      (state_3_o),
    .state_4_o      (state_4_o)
  );

endmodule
